// File: hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Scan target range sweeper package
// Item, result and table entry types, op and status codes, and the address
// odometer step shared by the sweeper modules.
// ----------------------------------------------------------------------------
package sts_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_NEXT   = 2'd1,
		OP_REWIND = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_FULL      = 3'd2,
		ST_ADDRESS   = 3'd3,
		ST_EXHAUSTED = 3'd4,
		ST_REWOUND   = 3'd5
	} status_t;

	localparam int CFG_DEFAULT_PORT_LOW  = 0;
	localparam int CFG_DEFAULT_PORT_HIGH = 1;

	localparam logic [15:0] DEFAULT_PORT_LOW_RST  = 16'd1;
	localparam logic [15:0] DEFAULT_PORT_HIGH_RST = 16'd1024;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] ip_low;
		logic [31:0] ip_high;
		logic        port_given;
		logic [15:0] port_low;
		logic [15:0] port_high;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
		logic [3:0]  target_index;
	} result_t;

	typedef struct packed {
		logic [31:0] ip_low;
		logic [31:0] ip_high;
		logic [15:0] port_low;
		logic [15:0] port_high;
	} entry_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
		logic        fresh;
	} cursor_t;

	// Steps the address odometer by one; the high byte runs fastest and
	// fixed octets pass the carry on untouched.
	function automatic logic [31:0] advance_ip(input logic [31:0] ip,
		input logic [31:0] lo, input logic [31:0] hi);
		logic [31:0] res;
		logic        carry;
		logic [7:0]  l;
		logic [7:0]  h;
		logic [7:0]  v;
		logic [8:0]  w;
		res   = '0;
		carry = 1'b1;
		for (int i = 3; i >= 0; i--) begin
			l = lo[8*i +: 8];
			h = hi[8*i +: 8];
			v = ip[8*i +: 8];
			if (carry && (l != h)) begin
				w = {1'b0, v} + 9'd1;
				if (w > {1'b0, h}) begin
					v = l;
				end else begin
					v     = w[7:0];
					carry = 1'b0;
				end
			end
			res[8*i +: 8] = v;
		end
		return res;
	endfunction

endpackage

// File: hdl/scan_target_range_sweeper.sv
// ----------------------------------------------------------------------------
// Scan target range sweeper
// Keeps a table of address and port ranges and hands out one address and
// port pair of the sweep for each next request.
//
//   Channel  Handshake                  Payload
//   item     item_valid / item_ready    item (op, ranges, ports)
//   result   result_valid / result_ready result (status, address, port, index)
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data (default ports)
//
// Each item's result is written to the output register as the item is
// accepted, and one item is accepted in every cycle while that register is
// free or being emptied. The current and following table entries are read
// from the two registered memory ports, so a step never waits on the table.
// Reset clears the counts and the cursor and sets the default ports to 1 and
// 1024; the table itself holds no reset. A stalled result holds the item
// channel.
// ----------------------------------------------------------------------------
module scan_target_range_sweeper import sts_pkg::*; #(
	parameter int MAX_TARGETS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CW = $clog2(MAX_TARGETS + 1);

	logic          accept;
	logic [15:0]   def_port_low_q;
	logic [15:0]   def_port_high_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] target_q;
	cursor_t       cursor_q;
	logic [CW-1:0] count_nx;
	logic [CW-1:0] target_nx;
	cursor_t       cursor_nx;
	result_t       step_result;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	entry_t        cur_entry;
	entry_t        nxt_entry;

	assign item_ready = !result_valid || result_ready;
	assign accept     = item_valid && item_ready;
	assign cfg_ready  = 1'b1;

	sts_step #(
		.MAX_TARGETS(MAX_TARGETS),
		.AW         (AW),
		.CW         (CW)
	) u_step (
		.do_step      (accept),
		.item         (item),
		.def_port_low (def_port_low_q),
		.def_port_high(def_port_high_q),
		.count        (count_q),
		.target       (target_q),
		.cursor       (cursor_q),
		.cur_entry    (cur_entry),
		.nxt_entry    (nxt_entry),
		.result       (step_result),
		.count_nx     (count_nx),
		.target_nx    (target_nx),
		.cursor_nx    (cursor_nx),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	sts_table #(
		.DEPTH(MAX_TARGETS),
		.AW   (AW),
		.CW   (CW)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_idx_a (target_nx),
		.rd_idx_b (target_nx + CW'(1)),
		.rd_data_a(cur_entry),
		.rd_data_b(nxt_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_port_low_q  <= DEFAULT_PORT_LOW_RST;
			def_port_high_q <= DEFAULT_PORT_HIGH_RST;
		end else if (cfg_valid) begin
			if (cfg_index == 1'(CFG_DEFAULT_PORT_LOW)) begin
				def_port_low_q <= cfg_data;
			end else begin
				def_port_high_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			target_q     <= '0;
			cursor_q     <= '{ip: '0, port: '0, fresh: 1'b1};
			result_valid <= 1'b0;
		end else begin
			count_q  <= count_nx;
			target_q <= target_nx;
			cursor_q <= cursor_nx;
			if (accept) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result <= step_result;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TARGETS))
		else $error("target count beyond table depth");

	a_target_bound: assert property (@(posedge clk) disable iff (!arst_n)
		target_q <= count_q)
		else $error("current target beyond target count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted item gave no result");

	a_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.op == OP_REWIND) |=> (target_q == '0) && cursor_q.fresh)
		else $error("rewind did not restart the sweep");

endmodule

// File: hdl/sts_table.sv
// ----------------------------------------------------------------------------
// Scan target table
// Target memory with one write port and two registered read ports. A write in
// the same cycle as a read of the same entry is forwarded to the read data.
// ----------------------------------------------------------------------------
module sts_table import sts_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [CW-1:0] rd_idx_a,
	input  logic [CW-1:0] rd_idx_b,
	output entry_t        rd_data_a,
	output entry_t        rd_data_b
);

	entry_t        mem [DEPTH];
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;

	// Indexes past the table are never used; they read entry zero instead.
	assign addr_a = (rd_idx_a < CW'(DEPTH)) ? rd_idx_a[AW-1:0] : '0;
	assign addr_b = (rd_idx_b < CW'(DEPTH)) ? rd_idx_b[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= (wr_en && (wr_addr == addr_a)) ? wr_data : mem[addr_a];
		rd_data_b <= (wr_en && (wr_addr == addr_b)) ? wr_data : mem[addr_b];
	end

endmodule

// File: hdl/sts_step.sv
// ----------------------------------------------------------------------------
// Scan target step logic
// Works out the result of one item and the next sweep state from the current
// target entry, the entry after it and the registered cursor.
// ----------------------------------------------------------------------------
module sts_step import sts_pkg::*; #(
	parameter int MAX_TARGETS = 16,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic          do_step,
	input  item_t         item,
	input  logic [15:0]   def_port_low,
	input  logic [15:0]   def_port_high,
	input  logic [CW-1:0] count,
	input  logic [CW-1:0] target,
	input  cursor_t       cursor,
	input  entry_t        cur_entry,
	input  entry_t        nxt_entry,
	output result_t       result,
	output logic [CW-1:0] count_nx,
	output logic [CW-1:0] target_nx,
	output cursor_t       cursor_nx,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_data
);

	logic          bad;
	logic [15:0]   pl;
	logic [15:0]   ph;
	logic [CW-1:0] target_inc;

	assign target_inc = target + CW'(1);
	assign wr_addr    = count[AW-1:0];

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (item.ip_low[8*i +: 8] > item.ip_high[8*i +: 8]) begin
				bad = 1'b1;
			end
		end
		if (item.port_given) begin
			pl = item.port_low;
			ph = item.port_high;
			if ((ph < pl) || ((pl == 16'd0) && (ph != 16'd0))) begin
				bad = 1'b1;
			end
		end else begin
			pl = def_port_low;
			ph = def_port_high;
			if (ph < pl) begin
				bad = 1'b1;
			end
		end
	end

	always_comb begin
		result    = '{status: ST_MALFORMED, dst_ip: '0, dst_port: '0, target_index: '0};
		count_nx  = count;
		target_nx = target;
		cursor_nx = cursor;
		wr_en     = 1'b0;
		wr_data   = '{ip_low: item.ip_low, ip_high: item.ip_high, port_low: pl,
			port_high: ph};
		if (do_step) begin
			case (op_t'(item.op))
				OP_ADD: begin
					if (bad) begin
						result.status = ST_MALFORMED;
					end else if (count >= CW'(MAX_TARGETS)) begin
						result.status = ST_FULL;
					end else begin
						wr_en               = 1'b1;
						result.status       = ST_ADDED;
						result.target_index = 4'(count);
						count_nx            = count + CW'(1);
					end
				end
				OP_NEXT: begin
					if (target >= count) begin
						result.status = ST_EXHAUSTED;
					end else if (cursor.fresh) begin
						cursor_nx     = '{ip: cur_entry.ip_low, port: cur_entry.port_low,
							fresh: 1'b0};
						result        = '{status: ST_ADDRESS, dst_ip: cur_entry.ip_low,
							dst_port: cur_entry.port_low, target_index: 4'(target)};
					end else if ((cursor.ip == cur_entry.ip_high) &&
						(cursor.port == cur_entry.port_high)) begin
						target_nx = target_inc;
						if (target_inc >= count) begin
							cursor_nx.fresh = 1'b1;
							result.status   = ST_EXHAUSTED;
						end else begin
							cursor_nx = '{ip: nxt_entry.ip_low, port: nxt_entry.port_low,
								fresh: 1'b0};
							result    = '{status: ST_ADDRESS, dst_ip: nxt_entry.ip_low,
								dst_port: nxt_entry.port_low,
								target_index: 4'(target_inc)};
						end
					end else begin
						if (cursor.port >= cur_entry.port_high) begin
							cursor_nx.port = cur_entry.port_low;
							cursor_nx.ip   = advance_ip(cursor.ip, cur_entry.ip_low,
								cur_entry.ip_high);
						end else begin
							cursor_nx.port = cursor.port + 16'd1;
						end
						result = '{status: ST_ADDRESS, dst_ip: cursor_nx.ip,
							dst_port: cursor_nx.port, target_index: 4'(target)};
					end
				end
				OP_REWIND: begin
					target_nx       = '0;
					cursor_nx.fresh = 1'b1;
					result.status   = ST_REWOUND;
				end
				default: begin
					result.status = ST_MALFORMED;
				end
			endcase
		end
	end

endmodule
